// ===== sv/sta_pkg.sv =====
// Package for the sorted term accumulator.
// Holds operation codes, result status codes, field widths and saturation bounds.
// No dependencies.
`timescale 1ns / 1ps

package sta_pkg;

  // Field widths
  localparam int COEF_W    = 32;
  localparam int EXP_W     = 16;
  localparam int CNT_OUT_W = 6;
  localparam int ENTRY_W   = COEF_W + EXP_W;

  // Operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_COMBINED  = 3'd1;
  localparam logic [2:0] ST_CANCELLED = 3'd2;
  localparam logic [2:0] ST_DROPPED   = 3'd3;
  localparam logic [2:0] ST_READ      = 3'd4;
  localparam logic [2:0] ST_CLEARED   = 3'd5;

  // Saturation bounds for Q16.16
  localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

endpackage

// ===== sv/sta_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port.
// Read data is registered. No dependencies.
`timescale 1ns / 1ps

module sta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/sorted_term_accumulator_top.sv =====
// Sorted term accumulator: top level.
// Uses sta_pkg (codes, widths) and sta_ram (term store).
`timescale 1ns / 1ps

// Holds a sparse polynomial as a table of up to MAX_TERMS terms sorted by
// falling exponent, in one RAM with a registered read port. One word is
// taken at a time; in_stall is high until the last result word of that
// word has been loaded into the output register. An insert walks the table
// from the top, one entry at a time, until it finds its place, then moves
// entries up (new term) or down (cancelled term) one at a time, and then
// loads its result word. Read-out gives one term per word, and an output
// stall holds every result word back. Sums saturate to the Q16.16 range.
// Unused operation codes are taken and give no result. Entries are not
// cleared after reset.
module sorted_term_accumulator_top #(
  parameter int MAX_TERMS = 32
) (
  input  logic                clk,
  input  logic                rst,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          operation,
  input  logic signed [31:0]  coef_in,
  input  logic signed [15:0]  exponent_in,
  // output channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          status,
  output logic signed [31:0]  coef_out,
  output logic signed [15:0]  exponent_out,
  output logic [5:0]          term_count,
  output logic                last,
  output logic                empty_res
);

  localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W = $clog2(MAX_TERMS + 1);

  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_NEW,
    S_SHUP,
    S_SHUP_WR,
    S_PUT,
    S_COMBINE,
    S_SHDN,
    S_SHDN_WR,
    S_RESULT,
    S_RD_ISSUE,
    S_RD_EMIT
  } state_t;

  state_t state;

  // Latched input word
  logic signed [sta_pkg::COEF_W-1:0] coef;
  logic signed [sta_pkg::EXP_W-1:0]  expo;

  // Table bookkeeping
  cnt_t held;
  cnt_t idx;
  cnt_t pos;
  cnt_t j;

  // Saturated sum and pending result
  logic signed [sta_pkg::COEF_W-1:0] sum;
  logic [2:0]                        res_status;
  logic signed [sta_pkg::COEF_W-1:0] res_coef;
  logic signed [sta_pkg::EXP_W-1:0]  res_exp;
  logic                              res_empty;

  // RAM signals
  logic                         ram_we;
  logic [IDX_W-1:0]             ram_waddr;
  logic [sta_pkg::ENTRY_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]             ram_raddr;
  logic [sta_pkg::ENTRY_W-1:0]  ram_rdata;

  logic signed [sta_pkg::COEF_W-1:0] rd_coef;
  logic signed [sta_pkg::EXP_W-1:0]  rd_exp;
  logic signed [sta_pkg::COEF_W:0]   raw_sum;
  logic signed [sta_pkg::COEF_W-1:0] sat_sum;
  logic                              out_free;
  logic                              out_load;
  logic                              in_take;
  cnt_t                              j_dec;
  cnt_t                              j_inc;
  cnt_t                              idx_inc;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign out_load = out_free && ((state == S_RESULT) || (state == S_RD_EMIT));

  assign j_dec   = j - cnt_t'(1);
  assign j_inc   = j + cnt_t'(1);
  assign idx_inc = idx + cnt_t'(1);

  assign rd_coef = ram_rdata[sta_pkg::ENTRY_W-1:sta_pkg::EXP_W];
  assign rd_exp  = ram_rdata[sta_pkg::EXP_W-1:0];

  // Saturating Q16.16 add of stored and incoming coefficient
  assign raw_sum = {rd_coef[sta_pkg::COEF_W-1], rd_coef} + {coef[sta_pkg::COEF_W-1], coef};
  always_comb begin
    if (raw_sum[sta_pkg::COEF_W] != raw_sum[sta_pkg::COEF_W-1]) begin
      sat_sum = raw_sum[sta_pkg::COEF_W] ? sta_pkg::COEF_MIN : sta_pkg::COEF_MAX;
    end else begin
      sat_sum = raw_sum[sta_pkg::COEF_W-1:0];
    end
  end

  // Read address: neighbor entry while shifting, else the walk index
  always_comb begin
    unique case (state)
      S_SHUP:  ram_raddr = j_dec[IDX_W-1:0];
      S_SHDN:  ram_raddr = j_inc[IDX_W-1:0];
      default: ram_raddr = idx[IDX_W-1:0];
    endcase
  end

  // Write port: shifted entry, new term or combined sum
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = j[IDX_W-1:0];
    ram_wdata = ram_rdata;
    unique case (state)
      S_SHUP_WR, S_SHDN_WR: begin
        ram_we = 1'b1;
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos[IDX_W-1:0];
        ram_wdata = {coef, expo};
      end
      S_COMBINE: begin
        ram_we    = (sum != '0);
        ram_waddr = idx[IDX_W-1:0];
        ram_wdata = {sum, expo};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  sta_ram #(
    .WIDTH (sta_pkg::ENTRY_W),
    .DEPTH (MAX_TERMS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer, table count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      // Output valid: set on a load, cleared once the word is taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            coef <= coef_in;
            expo <= exponent_in;
            idx  <= '0;
            priority if (operation == sta_pkg::OP_INSERT) begin
              state <= S_SRCH_RD;
            end else if (operation == sta_pkg::OP_READ) begin
              if (held == '0) begin
                res_status <= sta_pkg::ST_READ;
                res_coef   <= '0;
                res_exp    <= '0;
                res_empty  <= 1'b1;
                state      <= S_RESULT;
              end else begin
                state <= S_RD_ISSUE;
              end
            end else if (operation == sta_pkg::OP_CLEAR) begin
              held       <= '0;
              res_status <= sta_pkg::ST_CLEARED;
              res_coef   <= '0;
              res_exp    <= '0;
              res_empty  <= 1'b0;
              state      <= S_RESULT;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        // Walk down the table looking for the exponent
        S_SRCH_RD: begin
          state <= (idx == held) ? S_NEW : S_SRCH_CMP;
        end
        S_SRCH_CMP: begin
          sum <= sat_sum;
          priority if (rd_exp > expo) begin
            idx   <= idx_inc;
            state <= S_SRCH_RD;
          end else if (rd_exp == expo) begin
            state <= S_COMBINE;
          end else begin
            state <= S_NEW;
          end
        end
        // New exponent: drop when full, else open a slot
        S_NEW: begin
          res_exp   <= expo;
          res_empty <= 1'b0;
          if (held == cnt_t'(MAX_TERMS)) begin
            res_status <= sta_pkg::ST_DROPPED;
            res_coef   <= coef;
            state      <= S_RESULT;
          end else begin
            pos   <= idx;
            j     <= held;
            state <= S_SHUP;
          end
        end
        S_SHUP: begin
          state <= (j == pos) ? S_PUT : S_SHUP_WR;
        end
        S_SHUP_WR: begin
          j     <= j_dec;
          state <= S_SHUP;
        end
        S_PUT: begin
          held       <= held + cnt_t'(1);
          res_status <= sta_pkg::ST_INSERTED;
          res_coef   <= coef;
          state      <= S_RESULT;
        end
        // Matching exponent: keep the sum or remove the entry
        S_COMBINE: begin
          res_exp   <= expo;
          res_empty <= 1'b0;
          if (sum == '0) begin
            j     <= idx;
            state <= S_SHDN;
          end else begin
            res_status <= sta_pkg::ST_COMBINED;
            res_coef   <= sum;
            state      <= S_RESULT;
          end
        end
        S_SHDN: begin
          if (j_inc >= held) begin
            held       <= held - cnt_t'(1);
            res_status <= sta_pkg::ST_CANCELLED;
            res_coef   <= '0;
            state      <= S_RESULT;
          end else begin
            state <= S_SHDN_WR;
          end
        end
        S_SHDN_WR: begin
          j     <= j_inc;
          state <= S_SHDN;
        end
        // Single result word
        S_RESULT: begin
          if (out_free) begin
            status       <= res_status;
            coef_out     <= res_coef;
            exponent_out <= res_exp;
            term_count   <= sta_pkg::CNT_OUT_W'(held);
            last         <= 1'b1;
            empty_res    <= res_empty;
            state        <= S_IDLE;
          end
        end
        // Read-out, one term per word
        S_RD_ISSUE: begin
          state <= S_RD_EMIT;
        end
        S_RD_EMIT: begin
          if (out_free) begin
            status       <= sta_pkg::ST_READ;
            coef_out     <= rd_coef;
            exponent_out <= rd_exp;
            term_count   <= sta_pkg::CNT_OUT_W'(held);
            last         <= (idx_inc == held);
            empty_res    <= 1'b0;
            idx          <= idx_inc;
            state        <= (idx_inc == held) ? S_IDLE : S_RD_ISSUE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= cnt_t'(MAX_TERMS))
    else $error("term count above table size");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    in_take && (operation == sta_pkg::OP_CLEAR) |=> (held == '0))
    else $error("clear left terms in table");

  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_res |-> (status == sta_pkg::ST_READ) && last && (term_count == '0))
    else $error("empty read-out word malformed");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && (status == sta_pkg::ST_DROPPED) |->
      (held == cnt_t'(MAX_TERMS)))
    else $error("term dropped while table not full");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHUP_WR) |-> (j > pos) && (j <= held))
    else $error("insert shift out of range");

endmodule

// ===== sim/tb_top.sv =====
// Testbench for sorted_term_accumulator_top: drives insert, read, clear and unused words and
// checks every result word against a behavioral model of the sorted term table.
// Depends on sta_pkg and the sorted_term_accumulator_top RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int          TERM_CAP     = 32;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          DRAIN_CYCLES = 2 * TERM_CAP + 40;
  localparam int          PRINT_CAP    = 40;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;

  typedef struct {
    logic [2:0]         status;
    logic signed [31:0] coef;
    logic signed [15:0] expo;
    logic [5:0]         count;
    logic               last;
    logic               empty;
  } term_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         operation = sta_pkg::OP_INSERT;
  logic signed [31:0] coef_in = '0;
  logic signed [15:0] exponent_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         status;
  logic signed [31:0] coef_out;
  logic signed [15:0] exponent_out;
  logic [5:0]         term_count;
  logic               last;
  logic               empty_res;

  // model copy of the term table
  logic signed [31:0] term_coef [TERM_CAP];
  logic signed [15:0] term_exp  [TERM_CAP];
  int unsigned        term_total = 0;
  term_result_t       expected_results [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  sorted_term_accumulator_top #(.MAX_TERMS(TERM_CAP)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .coef_in      (coef_in),
    .exponent_in  (exponent_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .coef_out     (coef_out),
    .exponent_out (exponent_out),
    .term_count   (term_count),
    .last         (last),
    .empty_res    (empty_res)
  );

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sorted_term_accumulator_top: mismatch");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("error at cycle %0d: %s", cycle_count, what);
  endtask

  task automatic push_result(input logic [2:0] st, input logic signed [31:0] c,
                             input logic signed [15:0] e, input logic lst,
                             input logic emp);
    term_result_t r;
    r.status = st;
    r.coef   = c;
    r.expo   = e;
    r.count  = term_total[5:0];
    r.last   = lst;
    r.empty  = emp;
    expected_results.push_back(r);
  endtask

  // Model of one accepted word: updates the table copy, queues the result words.
  task automatic predict_word(input logic [1:0] op, input logic signed [31:0] c,
                              input logic signed [15:0] e);
    int unsigned        pos;
    logic signed [32:0] sum;
    logic signed [31:0] sat;
    pos = 0;
    case (op)
      sta_pkg::OP_INSERT: begin
        while (pos < term_total && term_exp[pos] > e) pos++;
        if (pos < term_total && term_exp[pos] == e) begin
          sum = {term_coef[pos][31], term_coef[pos]} + {c[31], c};
          // top two bits differ on overflow: clamp toward the sign
          if (sum[32] != sum[31]) sat = sum[32] ? sta_pkg::COEF_MIN : sta_pkg::COEF_MAX;
          else sat = sum[31:0];
          if (sat == 0) begin
            for (int unsigned i = pos; i + 1 < term_total; i++) begin
              term_coef[i] = term_coef[i + 1];
              term_exp[i]  = term_exp[i + 1];
            end
            term_total--;
            push_result(sta_pkg::ST_CANCELLED, '0, e, 1'b1, 1'b0);
          end else begin
            term_coef[pos] = sat;
            push_result(sta_pkg::ST_COMBINED, sat, e, 1'b1, 1'b0);
          end
        end else if (term_total >= TERM_CAP) begin
          push_result(sta_pkg::ST_DROPPED, c, e, 1'b1, 1'b0);
        end else begin
          for (int unsigned i = term_total; i > pos; i--) begin
            term_coef[i] = term_coef[i - 1];
            term_exp[i]  = term_exp[i - 1];
          end
          term_coef[pos] = c;
          term_exp[pos]  = e;
          term_total++;
          push_result(sta_pkg::ST_INSERTED, c, e, 1'b1, 1'b0);
        end
      end
      sta_pkg::OP_READ: begin
        if (term_total == 0) push_result(sta_pkg::ST_READ, '0, '0, 1'b1, 1'b1);
        for (int unsigned i = 0; i < term_total; i++)
          push_result(sta_pkg::ST_READ, term_coef[i], term_exp[i],
                      i + 1 == term_total, 1'b0);
      end
      sta_pkg::OP_CLEAR: begin
        term_total = 0;
        push_result(sta_pkg::ST_CLEARED, '0, '0, 1'b1, 1'b0);
      end
      default: ;
    endcase
  endtask

  // Send one word; valid stays high into the next word unless the sender idles.
  task automatic send_word(input logic [1:0] op, input logic signed [31:0] c,
                           input logic signed [15:0] e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    operation   <= op;
    coef_in     <= c;
    exponent_in <= e;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_word(op, c, e);
  endtask

  // receiver stall and result check
  always @(posedge clk) begin : result_check
    term_result_t want;
    out_stall <= ($urandom_range(99) < recv_idle_pct);
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected word status %0d exp %0d", status,
                                  exponent_out));
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", status, want.status));
        if (coef_out !== want.coef)
          report_mismatch($sformatf("coef got %0d want %0d", coef_out, want.coef));
        if (exponent_out !== want.expo)
          report_mismatch($sformatf("exponent got %0d want %0d", exponent_out, want.expo));
        if (term_count !== want.count)
          report_mismatch($sformatf("term_count got %0d want %0d", term_count, want.count));
        if (last !== want.last)
          report_mismatch($sformatf("last got %0b want %0b", last, want.last));
        if (empty_res !== want.empty)
          report_mismatch($sformatf("empty_res got %0b want %0b", empty_res, want.empty));
      end
    end
  end

  function automatic logic signed [31:0] coef_pick();
    case ($urandom_range(9))
      0:       return sta_pkg::COEF_MAX;
      1:       return sta_pkg::COEF_MIN;
      2:       return '0;
      3, 4:    return $urandom;
      default: return int'($urandom_range(8 * 65536)) - 4 * 65536;  // within +-4.0
    endcase
  endfunction

  // Term for an insert: often an exponent already held, to combine or cancel.
  task automatic pick_term(output logic signed [31:0] c, output logic signed [15:0] e);
    int unsigned idx;
    if (term_total > 0 && $urandom_range(2) == 0) begin
      idx = $urandom_range(term_total - 1);
      e   = term_exp[idx];
      c   = $urandom_range(1) ? -term_coef[idx] : coef_pick();
    end else begin
      case ($urandom_range(7))
        0:       e = 16'sh7FFF;
        1:       e = 16'sh8000;
        2:       e = 16'($urandom);
        default: e = 16'(int'($urandom_range(47)) - 24);
      endcase
      c = coef_pick();
    end
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // read-out and clear on an empty table
  task automatic test_empty_and_clear();
    send_word(sta_pkg::OP_READ, '1, '1);
    send_word(sta_pkg::OP_CLEAR, '1, '1);
  endtask

  // field extremes, a zero coefficient still stored, sorted read-out
  task automatic test_extremes_and_order();
    send_word(sta_pkg::OP_INSERT, sta_pkg::COEF_MAX, 16'sh7FFF);
    send_word(sta_pkg::OP_INSERT, sta_pkg::COEF_MIN, 16'sh8000);
    send_word(sta_pkg::OP_INSERT, '0, '0);
    send_word(sta_pkg::OP_INSERT, 32'sh0001_0000, 16'sd100);
    send_word(sta_pkg::OP_READ, '0, '0);
  endtask

  // sums past both bounds clamp and stay held
  task automatic test_saturation();
    send_word(sta_pkg::OP_INSERT, sta_pkg::COEF_MAX, 16'sh7FFF);
    send_word(sta_pkg::OP_INSERT, sta_pkg::COEF_MIN, 16'sh8000);
    send_word(sta_pkg::OP_READ, '0, '0);
  endtask

  // zero sums remove the entry, nonzero sums combine
  task automatic test_cancel();
    send_word(sta_pkg::OP_INSERT, -32'sh0001_0000, 16'sd100);
    send_word(sta_pkg::OP_INSERT, '0, '0);
    send_word(sta_pkg::OP_INSERT, sta_pkg::COEF_MIN, 16'sh7FFF);
    send_word(sta_pkg::OP_INSERT, 32'sd1, 16'sh7FFF);
    send_word(sta_pkg::OP_READ, '0, '0);
  endtask

  // unused operation code gives no result and leaves the table alone
  task automatic test_unused_code();
    send_word(OP_UNUSED, '1, '1);
    send_word(OP_UNUSED, '0, '0);
    send_word(sta_pkg::OP_READ, '0, '0);
  endtask

  task automatic test_clear_held();
    send_word(sta_pkg::OP_CLEAR, $urandom, 16'($urandom));
    send_word(sta_pkg::OP_READ, $urandom, 16'($urandom));
  endtask

  // fill the table, then drops, combines and a cancel on a full table
  task automatic test_table_full();
    logic signed [31:0] c;
    logic signed [15:0] e;
    int                 tries;
    int unsigned        idx;
    send_word(sta_pkg::OP_CLEAR, $urandom, 16'($urandom));
    tries = 0;
    while (term_total < TERM_CAP && tries < 100) begin
      send_word(sta_pkg::OP_INSERT, coef_pick(), 16'($urandom));
      tries++;
    end
    repeat (3) send_word(sta_pkg::OP_INSERT, coef_pick(), 16'($urandom));
    idx = $urandom_range(term_total - 1);
    send_word(sta_pkg::OP_INSERT, coef_pick(), term_exp[idx]);
    send_word(sta_pkg::OP_READ, $urandom, 16'($urandom));
    idx = $urandom_range(term_total - 1);
    send_word(sta_pkg::OP_INSERT, -term_coef[idx], term_exp[idx]);
    pick_term(c, e);
    send_word(sta_pkg::OP_INSERT, c, e);
    send_word(sta_pkg::OP_INSERT, coef_pick(), 16'($urandom));
    send_word(sta_pkg::OP_READ, $urandom, 16'($urandom));
  endtask

  // random mix of all operations, mostly inserts
  task automatic test_random_mix(input int words);
    logic signed [31:0] c;
    logic signed [15:0] e;
    logic [1:0]         op;
    int                 r;
    int                 done;
    done = 0;
    while (done < words) begin
      r = $urandom_range(99);
      pick_term(c, e);
      if (r < 76) op = sta_pkg::OP_INSERT;
      else if (r < 88) op = sta_pkg::OP_READ;
      else if (r < 94) op = sta_pkg::OP_CLEAR;
      else op = OP_UNUSED;
      if (op != sta_pkg::OP_INSERT) begin
        c = $urandom;
        e = 16'($urandom);
      end
      send_word(op, c, e);
      if (op != OP_UNUSED) done++;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idling(8, 86);
    test_empty_and_clear();
    test_extremes_and_order();
    test_saturation();
    test_cancel();
    test_unused_code();
    test_clear_held();
    test_table_full();
    test_random_mix(75);

    set_idling(86, 8);
    test_table_full();
    test_random_mix(75);

    set_idling(0, 0);
    test_table_full();
    test_random_mix(75);

    // drain: all results back, then allow for a late stray word
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", expected_results.size()));

    if (mismatch_count == 0) begin
      $display("sorted_term_accumulator_top: match");
    end else begin
      $display("sorted_term_accumulator_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== sorted_term_accumulator_top.f =====
sv/sta_pkg.sv
sv/sta_ram.sv
sv/sorted_term_accumulator_top.sv
sim/tb_top.sv
